// ===== design/pgv_pkg.sv =====
// Shared widths, status codes and the grid summary record for the patch grid validator.
package pgv_pkg;

    // Field and state widths
    localparam int unsigned COORD_W  = 32;
    localparam int unsigned SIDE_W   = 14;
    localparam int unsigned DIM_W    = 15;
    localparam int unsigned COUNT_W  = 28;
    localparam int unsigned LWIDTH_W = 15;
    localparam int unsigned RAW_W    = 27;
    localparam int unsigned POOLED_W = 24;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned CFG_W    = RAW_W;

    // Defaults for the top-level parameters
    localparam int unsigned DEF_MAX_SIDE    = 10240;
    localparam int unsigned DEF_POOL_FACTOR = 3;

    // Saturation limits
    localparam logic [COUNT_W-1:0]  COUNT_MAX  = {COUNT_W{1'b1}};
    localparam logic [SIDE_W-1:0]   ROW_MAX    = {SIDE_W{1'b1}};
    localparam logic [LWIDTH_W-1:0] LWIDTH_MAX = {LWIDTH_W{1'b1}};

    // Configuration register indexes
    localparam logic CFG_PATCH_TOTAL        = 1'b0;
    localparam logic CFG_POOLED_TOKEN_COUNT = 1'b1;

    // Status codes
    localparam logic [STATUS_W-1:0] STATUS_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_BAD_COUNTS = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_RANGE      = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_NOT_DIV    = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_ORDER      = 3'd4;

    // Summary of one finished grid, handed from front to back
    typedef struct packed {
        logic [COUNT_W-1:0] item_count;
        logic [SIDE_W-1:0]  max_column;
        logic [SIDE_W-1:0]  max_row;
        logic               range_failed;
        logic               order_ok;
        logic [COUNT_W-1:0] learned_width;
    } t_grid_summary;

endpackage

// ===== design/pgv_front.sv =====
// Front end: per-coordinate counting, maxima, range check and row-major tracking.
module pgv_front
    import pgv_pkg::*;
#(
    parameter int unsigned MAX_SIDE = DEF_MAX_SIDE
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_accept,
    input  logic signed [COORD_W-1:0] i_x_coord,
    input  logic signed [COORD_W-1:0] i_y_coord,
    input  logic                      i_is_last,
    output logic                      o_push,
    output t_grid_summary             o_summary
);

    logic [COUNT_W-1:0]  r_count,     n_count;
    logic [SIDE_W-1:0]   r_max_col,   n_max_col;
    logic [SIDE_W-1:0]   r_max_row,   n_max_row;
    logic                r_range_bad, n_range_bad;
    logic                r_first_row, n_first_row;
    logic [LWIDTH_W-1:0] r_lwidth,    n_lwidth;
    logic [SIDE_W-1:0]   r_exp_col,   n_exp_col;
    logic [SIDE_W-1:0]   r_exp_row,   n_exp_row;
    logic                r_order_ok,  n_order_ok;

    logic                in_range;
    logic                x_is_count;
    logic                x_is_zero;
    logic                y_is_zero;
    logic                y_is_one;
    logic                at_expected;
    logic [LWIDTH_W-1:0] count_sat;
    logic [SIDE_W-1:0]   base_col;
    logic [SIDE_W-1:0]   base_row;
    logic [LWIDTH_W-1:0] base_lwidth;
    logic [SIDE_W-1:0]   step_col;
    logic                step_wrap;
    logic [SIDE_W-1:0]   adv_col;
    logic [SIDE_W-1:0]   adv_row;

    // Classify the coordinate
    always_comb begin
        in_range    = !i_x_coord[COORD_W-1] && !i_y_coord[COORD_W-1] &&
                      ($unsigned(i_x_coord) < COORD_W'(MAX_SIDE)) &&
                      ($unsigned(i_y_coord) < COORD_W'(MAX_SIDE));
        x_is_count  = ($unsigned(i_x_coord) == COORD_W'(r_count));
        x_is_zero   = (i_x_coord == '0);
        y_is_zero   = (i_y_coord == '0);
        y_is_one    = ($unsigned(i_y_coord) == COORD_W'(1));
        at_expected = ($unsigned(i_x_coord) == COORD_W'(r_exp_col)) &&
                      ($unsigned(i_y_coord) == COORD_W'(r_exp_row));
        count_sat   = (|r_count[COUNT_W-1:LWIDTH_W]) ? LWIDTH_MAX : r_count[LWIDTH_W-1:0];
    end

    // Advance the expected position, from the row start or from the tracked position
    always_comb begin
        base_col    = r_first_row ? '0 : r_exp_col;
        base_row    = r_first_row ? SIDE_W'(1) : r_exp_row;
        base_lwidth = r_first_row ? count_sat : r_lwidth;
        step_col    = base_col + SIDE_W'(1);
        step_wrap   = ({1'b0, step_col} >= base_lwidth);
        adv_col     = step_wrap ? '0 : step_col;
        adv_row     = (step_wrap && (base_row != ROW_MAX)) ? base_row + SIDE_W'(1) : base_row;
    end

    // Next stream state
    always_comb begin
        n_count     = (r_count != COUNT_MAX) ? r_count + COUNT_W'(1) : r_count;
        n_max_col   = r_max_col;
        n_max_row   = r_max_row;
        n_range_bad = r_range_bad;
        n_first_row = r_first_row;
        n_lwidth    = r_lwidth;
        n_exp_col   = r_exp_col;
        n_exp_row   = r_exp_row;
        n_order_ok  = r_order_ok;

        if (r_order_ok) begin
            if (r_first_row) begin
                if (y_is_zero && x_is_count) begin
                    n_order_ok = 1'b1;
                end else if (x_is_zero && y_is_one && (r_count != '0)) begin
                    n_first_row = 1'b0;
                    n_lwidth    = count_sat;
                    n_exp_col   = adv_col;
                    n_exp_row   = adv_row;
                end else begin
                    n_order_ok = 1'b0;
                end
            end else if (at_expected) begin
                n_exp_col = adv_col;
                n_exp_row = adv_row;
            end else begin
                n_order_ok = 1'b0;
            end
        end

        if (!in_range) begin
            n_range_bad = 1'b1;
        end else begin
            if (i_x_coord[SIDE_W-1:0] > r_max_col) n_max_col = i_x_coord[SIDE_W-1:0];
            if (i_y_coord[SIDE_W-1:0] > r_max_row) n_max_row = i_y_coord[SIDE_W-1:0];
        end
    end

    // Summary of the grid as it stands after this coordinate
    always_comb begin
        o_push                  = i_accept && i_is_last;
        o_summary.item_count    = n_count;
        o_summary.max_column    = n_max_col;
        o_summary.max_row       = n_max_row;
        o_summary.range_failed  = n_range_bad;
        o_summary.order_ok      = n_order_ok;
        o_summary.learned_width = n_first_row ? n_count : COUNT_W'(n_lwidth);
    end

    // Hold stream state; drop back to the start after the last coordinate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_is_last)) begin
            r_count     <= '0;
            r_max_col   <= '0;
            r_max_row   <= '0;
            r_range_bad <= 1'b0;
            r_first_row <= 1'b1;
            r_lwidth    <= '0;
            r_exp_col   <= '0;
            r_exp_row   <= '0;
            r_order_ok  <= 1'b1;
        end else if (i_accept) begin
            r_count     <= n_count;
            r_max_col   <= n_max_col;
            r_max_row   <= n_max_row;
            r_range_bad <= n_range_bad;
            r_first_row <= n_first_row;
            r_lwidth    <= n_lwidth;
            r_exp_col   <= n_exp_col;
            r_exp_row   <= n_exp_row;
            r_order_ok  <= n_order_ok;
        end
    end

endmodule

// ===== design/pgv_queue.sv =====
// Short queue of grid summaries between front and back.
module pgv_queue
    import pgv_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  t_grid_summary i_push_data,
    input  logic          i_pop,
    output t_grid_summary o_head,
    output logic          o_empty,
    output logic          o_full
);

    localparam int unsigned DEPTH = 4;
    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_grid_summary      r_entry [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_fill;

    assign o_head  = r_entry[r_rd_ptr];
    assign o_empty = (r_fill == '0);
    assign o_full  = (r_fill == CNT_W'(DEPTH));

    // Store the incoming summary
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_push_data;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            if (i_pop)  r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            if (i_push && !i_pop) begin
                r_fill <= r_fill + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_fill <= r_fill - CNT_W'(1);
            end
        end
    end

`ifndef SYNTH
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("queue written while full");

    a_no_pop_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("queue read while empty");

    a_fill_tracks_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill != CNT_W'(DEPTH)) |-> (PTR_W'(r_wr_ptr - r_rd_ptr) == PTR_W'(r_fill)))
        else $error("fill count disagrees with pointers");
`endif

endmodule

// ===== design/pgv_back.sv =====
// Back end: grid status from a summary, two stages with the output register last.
module pgv_back
    import pgv_pkg::*;
#(
    parameter int unsigned POOL_FACTOR = DEF_POOL_FACTOR
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_head_valid,
    input  t_grid_summary       i_head,
    output logic                o_pop,
    input  logic [RAW_W-1:0]    i_patch_total,
    input  logic [POOLED_W-1:0] i_pooled_token_count,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [STATUS_W-1:0] o_status,
    output logic [SIDE_W-1:0]   o_grid_width,
    output logic [SIDE_W-1:0]   o_grid_height
);

    // Division by the pool factor as a multiply by its reciprocal; exact for DIM_W-bit values
    localparam int unsigned DIV_SHIFT = DIM_W + 5;
    localparam int unsigned RECIP_W   = DIV_SHIFT + 1;
    localparam logic [RECIP_W-1:0] DIV_RECIP =
        RECIP_W'(((2 ** DIV_SHIFT) + POOL_FACTOR - 1) / POOL_FACTOR);
    localparam int unsigned PROD_W    = DIM_W + RECIP_W;
    localparam int unsigned PF_SQ     = POOL_FACTOR * POOL_FACTOR;
    localparam int unsigned AREA_W    = 2 * DIM_W;
    localparam int unsigned TOKEN_W   = POOLED_W + 7;

    // Stage one registers
    logic                r_s1_valid;
    logic [DIM_W-1:0]    r_s1_w;
    logic [DIM_W-1:0]    r_s1_h;
    logic [DIM_W-1:0]    r_s1_qw;
    logic [DIM_W-1:0]    r_s1_qh;
    logic [AREA_W-1:0]   r_s1_area;
    logic                r_s1_count_bad;
    logic                r_s1_range_bad;
    logic                r_s1_order_bad;

    // Output registers
    logic                r_o_valid;
    logic [STATUS_W-1:0] r_status;
    logic [SIDE_W-1:0]   r_width;
    logic [SIDE_W-1:0]   r_height;

    logic                s1_ready;
    logic                s2_ready;
    logic [DIM_W-1:0]    w;
    logic [DIM_W-1:0]    h;
    logic [PROD_W-1:0]   w_recip;
    logic [PROD_W-1:0]   h_recip;
    logic [TOKEN_W-1:0]  raw_expected;
    logic                count_bad;
    logic [DIM_W+3:0]    qw_back;
    logic [DIM_W+3:0]    qh_back;
    logic [DIM_W-1:0]    rem_w;
    logic [DIM_W-1:0]    rem_h;
    logic [AREA_W-1:0]   pooled_area;
    logic                div_bad;
    logic [STATUS_W-1:0] n_status;

    // Stall chain
    assign s2_ready = !r_o_valid || !i_stall;
    assign s1_ready = !r_s1_valid || s2_ready;
    assign o_pop    = i_head_valid && s1_ready;

    // Stage one: sides, quotients, area, count and order checks
    always_comb begin
        w            = DIM_W'(i_head.max_column) + DIM_W'(1);
        h            = DIM_W'(i_head.max_row) + DIM_W'(1);
        w_recip      = PROD_W'(w) * PROD_W'(DIV_RECIP);
        h_recip      = PROD_W'(h) * PROD_W'(DIV_RECIP);
        raw_expected = TOKEN_W'(i_pooled_token_count) * TOKEN_W'(PF_SQ);
        count_bad    = (i_patch_total == '0) || (i_pooled_token_count == '0) ||
                       (TOKEN_W'(i_patch_total) != raw_expected) ||
                       (i_head.item_count != COUNT_W'(i_patch_total));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_ready) begin
            r_s1_valid <= i_head_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1_w         <= w;
            r_s1_h         <= h;
            r_s1_qw        <= w_recip[DIV_SHIFT +: DIM_W];
            r_s1_qh        <= h_recip[DIV_SHIFT +: DIM_W];
            r_s1_area      <= AREA_W'(w) * AREA_W'(h);
            r_s1_count_bad <= count_bad;
            r_s1_range_bad <= i_head.range_failed;
            r_s1_order_bad <= !i_head.order_ok ||
                              (i_head.learned_width != COUNT_W'(w));
        end
    end

    // Stage two: divisibility and status by precedence
    always_comb begin
        qw_back     = (DIM_W+4)'(r_s1_qw) * (DIM_W+4)'(POOL_FACTOR);
        qh_back     = (DIM_W+4)'(r_s1_qh) * (DIM_W+4)'(POOL_FACTOR);
        rem_w       = r_s1_w - qw_back[DIM_W-1:0];
        rem_h       = r_s1_h - qh_back[DIM_W-1:0];
        pooled_area = AREA_W'(r_s1_qw) * AREA_W'(r_s1_qh);
        div_bad     = (rem_w != '0) || (rem_h != '0) ||
                      (r_s1_area != AREA_W'(i_patch_total)) ||
                      (pooled_area != AREA_W'(i_pooled_token_count));
        if (r_s1_count_bad) begin
            n_status = STATUS_BAD_COUNTS;
        end else if (r_s1_range_bad) begin
            n_status = STATUS_RANGE;
        end else if (div_bad) begin
            n_status = STATUS_NOT_DIV;
        end else if (r_s1_order_bad) begin
            n_status = STATUS_ORDER;
        end else begin
            n_status = STATUS_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (s2_ready) begin
            r_o_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_ready && r_s1_valid) begin
            r_status <= n_status;
            r_width  <= (n_status == STATUS_OK) ? r_s1_w[SIDE_W-1:0] : '0;
            r_height <= (n_status == STATUS_OK) ? r_s1_h[SIDE_W-1:0] : '0;
        end
    end

    assign o_valid       = r_o_valid;
    assign o_status      = r_status;
    assign o_grid_width  = r_width;
    assign o_grid_height = r_height;

`ifndef SYNTH
    a_sides_only_when_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && (r_status != STATUS_OK)) |-> ((r_width == '0) && (r_height == '0)))
        else $error("grid sides given with an error status");

    a_pop_fills_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_s1_valid)
        else $error("popped summary lost before stage one");

    a_stage_holds_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_o_valid && i_stall) |=> (r_s1_valid && $stable(r_s1_w)))
        else $error("stage one changed while blocked");
`endif

endmodule

// ===== design/patch_grid_validator_unit.sv =====
// Top level of the patch grid validator: configuration registers, front, queue and back.
//
// Takes one (x,y) coordinate per clock and gives one status with grid width and
// height for each coordinate marked last, registered in the queue, then in the back
// end's stage-one and output registers. Coordinates are tracked in the front end;
// each finished grid's summary goes into a four-entry queue, and a two-stage
// back end (reciprocal multiply for the pool-factor quotients, then the area and
// remainder checks) produces the status. The input stalls only while that queue
// is full, i.e. when four finished grids wait behind a stalled output. Register
// 0 is the raw patch count, register 1 the pooled token count; write them while idle.
module patch_grid_validator_unit
    import pgv_pkg::*;
#(
    parameter int unsigned MAX_SIDE    = DEF_MAX_SIDE,
    parameter int unsigned POOL_FACTOR = DEF_POOL_FACTOR
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic signed [COORD_W-1:0] i_x_coord,
    input  logic signed [COORD_W-1:0] i_y_coord,
    input  logic                      i_is_last,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [STATUS_W-1:0]       o_status,
    output logic [SIDE_W-1:0]         o_grid_width,
    output logic [SIDE_W-1:0]         o_grid_height,
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_index,
    input  logic [CFG_W-1:0]          i_cfg_data
);

    logic [RAW_W-1:0]    r_patch_total;
    logic [POOLED_W-1:0] r_pooled_token_count;

    logic                accept;
    logic                push;
    t_grid_summary       push_summary;
    logic                pop;
    t_grid_summary       head;
    logic                q_empty;
    logic                q_full;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_patch_total        <= '0;
            r_pooled_token_count <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PATCH_TOTAL:        r_patch_total        <= i_cfg_data[RAW_W-1:0];
                CFG_POOLED_TOKEN_COUNT: r_pooled_token_count <= i_cfg_data[POOLED_W-1:0];
                default:                r_patch_total        <= r_patch_total;
            endcase
        end
    end

    // Take a coordinate whenever the queue has room
    assign o_stall = q_full;
    assign accept  = i_valid && !q_full;

    pgv_front #(
        .MAX_SIDE (MAX_SIDE)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_x_coord (i_x_coord),
        .i_y_coord (i_y_coord),
        .i_is_last (i_is_last),
        .o_push    (push),
        .o_summary (push_summary)
    );

    pgv_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_summary),
        .i_pop       (pop),
        .o_head      (head),
        .o_empty     (q_empty),
        .o_full      (q_full)
    );

    pgv_back #(
        .POOL_FACTOR (POOL_FACTOR)
    ) u_back (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_head_valid         (!q_empty),
        .i_head               (head),
        .o_pop                (pop),
        .i_patch_total        (r_patch_total),
        .i_pooled_token_count (r_pooled_token_count),
        .o_valid              (o_valid),
        .i_stall              (i_stall),
        .o_status             (o_status),
        .o_grid_width         (o_grid_width),
        .o_grid_height        (o_grid_height)
    );

endmodule
